// ===== design/clb_pkg.sv =====
package clb_pkg;

    typedef enum logic [3:0] {
        ST_NORMAL     = 4'd0,
        ST_SLASH      = 4'd1,
        ST_LINE       = 4'd2,
        ST_BLOCK      = 4'd3,
        ST_BLOCK_STAR = 4'd4,
        ST_STR        = 4'd5,
        ST_STR_ESC    = 4'd6,
        ST_CHR        = 4'd7,
        ST_CHR_ESC    = 4'd8
    } t_state;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
    } t_out_item;

    typedef struct packed {
        logic [1:0] n;
        t_out_item  r0;
        t_out_item  r1;
    } t_step_res;

endpackage

// ===== design/c_comment_literal_blanker.sv =====
// c comment and literal blanker
// input channel: i_in_valid / o_in_stall carry one text byte per item
// with a last-byte flag. output channel: o_out_valid / i_out_stall carry
// one blanked byte per item, with run_last set on the final byte caused
// by each input item.
// an accepted item updates the parse state in the same cycle and its
// results enter a small register queue, so with the queue empty the first
// result is visible in the cycle after acceptance.
// throughput: one input item per cycle. most items give one result, a
// held slash gives none and the byte after it gives two; the queue
// (QUEUE_DEPTH entries) absorbs the extra byte and the input stalls while
// fewer than two entries are free. the single-byte output port sets the
// long-run output rate at one byte per cycle unless the receiver stalls.
// reset returns the parser to normal code and empties the queue.
// while the receiver stalls, the head byte holds and the queue fills;
// the input then stalls until room for two bytes returns.
module c_comment_literal_blanker #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  clb_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output clb_pkg::t_out_item o_out_item
);

    logic               accept;
    clb_pkg::t_step_res res;

    assign accept = i_in_valid && !o_in_stall;

    clb_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .o_res    (res)
    );

    clb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (res),
        .o_full      (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== design/clb_parser.sv =====
module clb_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  clb_pkg::t_in_item i_item,
    output clb_pkg::t_step_res o_res
);

    clb_pkg::t_state r_state;
    clb_pkg::t_state n_state;
    logic [7:0] c;
    logic [7:0] blank;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [1:0] cnt;

    assign c     = i_item.in_char;
    assign blank = (c == clb_pkg::CH_NL) ? clb_pkg::CH_NL : clb_pkg::CH_SPACE;

    always_comb begin
        n_state = r_state;
        c0      = blank;
        c1      = blank;
        cnt     = 2'd1;
        case (r_state)
            clb_pkg::ST_SLASH: begin
                cnt = 2'd2;
                if (c == clb_pkg::CH_SLASH) begin
                    c0      = clb_pkg::CH_SPACE;
                    c1      = clb_pkg::CH_SPACE;
                    n_state = clb_pkg::ST_LINE;
                end else if (c == clb_pkg::CH_STAR) begin
                    c0      = clb_pkg::CH_SPACE;
                    c1      = clb_pkg::CH_SPACE;
                    n_state = clb_pkg::ST_BLOCK;
                end else begin
                    c0      = clb_pkg::CH_SLASH;
                    c1      = c;
                    n_state = clb_pkg::ST_NORMAL;
                end
            end
            clb_pkg::ST_LINE: begin
                if (c == clb_pkg::CH_NL) n_state = clb_pkg::ST_NORMAL;
            end
            clb_pkg::ST_BLOCK: begin
                if (c == clb_pkg::CH_STAR) n_state = clb_pkg::ST_BLOCK_STAR;
            end
            clb_pkg::ST_BLOCK_STAR: begin
                if (c == clb_pkg::CH_SLASH) begin
                    n_state = clb_pkg::ST_NORMAL;
                end else if (c != clb_pkg::CH_STAR) begin
                    n_state = clb_pkg::ST_BLOCK;
                end
            end
            clb_pkg::ST_STR: begin
                if (c == clb_pkg::CH_BSLASH) begin
                    n_state = clb_pkg::ST_STR_ESC;
                end else if (c == clb_pkg::CH_DQUOTE) begin
                    n_state = clb_pkg::ST_NORMAL;
                end
            end
            clb_pkg::ST_STR_ESC: begin
                n_state = clb_pkg::ST_STR;
            end
            clb_pkg::ST_CHR: begin
                if (c == clb_pkg::CH_BSLASH) begin
                    n_state = clb_pkg::ST_CHR_ESC;
                end else if (c == clb_pkg::CH_SQUOTE) begin
                    n_state = clb_pkg::ST_NORMAL;
                end
            end
            clb_pkg::ST_CHR_ESC: begin
                n_state = clb_pkg::ST_CHR;
            end
            default: begin
                if (c == clb_pkg::CH_SLASH) begin
                    cnt     = 2'd0;
                    n_state = clb_pkg::ST_SLASH;
                end else if (c == clb_pkg::CH_DQUOTE) begin
                    c0      = clb_pkg::CH_SPACE;
                    n_state = clb_pkg::ST_STR;
                end else if (c == clb_pkg::CH_SQUOTE) begin
                    c0      = clb_pkg::CH_SPACE;
                    n_state = clb_pkg::ST_CHR;
                end else begin
                    c0      = c;
                    n_state = clb_pkg::ST_NORMAL;
                end
            end
        endcase

        // end of text flushes a held slash and returns the parser to normal code
        if (i_item.in_last) begin
            if (n_state == clb_pkg::ST_SLASH) begin
                if (cnt == 2'd0) begin
                    c0 = clb_pkg::CH_SLASH;
                end else begin
                    c1 = clb_pkg::CH_SLASH;
                end
                cnt = cnt + 2'd1;
            end
            n_state = clb_pkg::ST_NORMAL;
        end

        o_res.n           = i_accept ? cnt : 2'd0;
        o_res.r0.out_char = c0;
        o_res.r0.run_last = (cnt == 2'd1);
        o_res.r1.out_char = c1;
        o_res.r1.run_last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clb_pkg::ST_NORMAL;
        end else if (i_accept) begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/clb_queue.sv =====
module clb_queue #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  clb_pkg::t_step_res i_res,
    output logic               o_full,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output clb_pkg::t_out_item o_out_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    clb_pkg::t_out_item r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic [PW-1:0] wr1;
    logic [PW-1:0] wr2;
    logic [PW-1:0] rd1;
    logic          pop;

    function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign wr1 = inc(r_wr);
    assign wr2 = inc(wr1);
    assign rd1 = inc(r_rd);

    assign o_out_valid = (r_count != '0);
    assign o_out_item  = r_mem[r_rd];
    assign pop         = o_out_valid && !i_out_stall;
    // room for two items keeps the input open
    assign o_full      = (r_count > CW'(DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_res.n != 2'd0) r_mem[r_wr] <= i_res.r0;
        if (i_res.n == 2'd2) r_mem[wr1] <= i_res.r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_res.n == 2'd1) begin
                r_wr <= wr1;
            end else if (i_res.n == 2'd2) begin
                r_wr <= wr2;
            end
            if (pop) r_rd <= rd1;
            r_count <= r_count + CW'(i_res.n) - CW'(pop);
        end
    end

endmodule

// ===== design/clb_checker.sv =====
module clb_port_checks (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input clb_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input clb_pkg::t_out_item o_out_item
);

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output item changed");

    a_empty_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty queue");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall
        && (i_in_item.in_last || i_in_item.in_char != clb_pkg::CH_SLASH)
        |=> o_out_valid)
        else $error("item produced no result");

endmodule

bind c_comment_literal_blanker clb_port_checks u_clb_checker (.*);
